// ===== design/lruc_pkg.sv =====
package lruc_pkg;

	localparam int KEY_PORT_W   = 16;
	localparam int VALUE_PORT_W = 32;
	localparam int CAP_W        = 5;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	localparam logic OP_GET = 1'b0;
	localparam logic OP_PUT = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_TOUCH,
		ST_FINISH
	} lruc_state_t;

	typedef struct packed {
		logic key_we;
		logic val_we;
		logic rank_we;
	} lruc_wr_t;

	typedef struct packed {
		logic eq;
		logic gt;
		logic lt;
	} lruc_cmp_t;

endpackage

// ===== design/lruc_cmp.sv =====
module lruc_cmp #(
	parameter int KEY_BITS = 16,
	parameter int RANK_W   = 4
) (
	input  logic [KEY_BITS-1:0] key_a,
	input  logic [KEY_BITS-1:0] key_b,
	input  logic [RANK_W-1:0]   rank_a,
	input  logic [RANK_W-1:0]   rank_b,
	output lruc_pkg::lruc_cmp_t res
);

	always_comb begin
		res.eq = (key_a == key_b);
		res.gt = (rank_a > rank_b);
		res.lt = (rank_a < rank_b);
	end

endmodule

// ===== design/lruc_store.sv =====
module lruc_store #(
	parameter int ENTRIES    = 16,
	parameter int KEY_BITS   = 16,
	parameter int VALUE_BITS = 32,
	parameter int IDX_W      = 4
) (
	input  logic                  clk,
	input  lruc_pkg::lruc_wr_t    wr,
	input  logic [IDX_W-1:0]      rd_addr,
	input  logic [IDX_W-1:0]      val_raddr,
	input  logic [IDX_W-1:0]      kv_waddr,
	input  logic [KEY_BITS-1:0]   key_wdata,
	input  logic [VALUE_BITS-1:0] val_wdata,
	input  logic [IDX_W-1:0]      rank_waddr,
	input  logic [IDX_W-1:0]      rank_wdata,
	output logic [KEY_BITS-1:0]   key_rdata,
	output logic [IDX_W-1:0]      rank_rdata,
	output logic [VALUE_BITS-1:0] val_rdata
);

	logic [KEY_BITS-1:0]   key_mem  [ENTRIES];
	logic [VALUE_BITS-1:0] val_mem  [ENTRIES];
	logic [IDX_W-1:0]      rank_mem [ENTRIES];

	always_ff @(posedge clk) begin
		if (wr.key_we) begin
			key_mem[kv_waddr] <= key_wdata;
		end
		key_rdata <= key_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (wr.val_we) begin
			val_mem[kv_waddr] <= val_wdata;
		end
		val_rdata <= val_mem[val_raddr];
	end

	always_ff @(posedge clk) begin
		if (wr.rank_we) begin
			rank_mem[rank_waddr] <= rank_wdata;
		end
		rank_rdata <= rank_mem[rd_addr];
	end

endmodule

// ===== design/lru_key_value_cache_top.sv =====
// channel  | ports                              | handshake
// ---------+------------------------------------+-------------------------------
// request  | operation, key, write_value        | taken when start && !busy
// result   | hit, read_value                    | valid for the one cycle done=1
// config   | cfg_wdata (capacity)               | written when cfg_we=1
//
// A get that hits or any put makes one sweep over the key and rank memory to
// look up and one sweep over the rank memory to reorder; a get that misses
// makes only the lookup sweep.
// Reset clears the valid bits and occupancy and sets capacity to 16; no clearing pass.
// The result cannot be stalled; a new item is taken in the cycle done is high.
module lru_key_value_cache_top #(
	parameter int ENTRIES    = 16,
	parameter int KEY_BITS   = 16,
	parameter int VALUE_BITS = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic                              operation,
	input  logic [lruc_pkg::KEY_PORT_W-1:0]   key,
	input  logic [lruc_pkg::VALUE_PORT_W-1:0] write_value,
	output logic                              done,
	output logic                              hit,
	output logic [lruc_pkg::VALUE_PORT_W-1:0] read_value,
	input  logic                              cfg_we,
	input  logic [lruc_pkg::CAP_W-1:0]        cfg_wdata
);

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam int CMP_W = (CNT_W > lruc_pkg::CAP_W) ? CNT_W : lruc_pkg::CAP_W;

	lruc_pkg::lruc_state_t state_q, state_d;

	logic [CNT_W-1:0]          cnt_q;
	logic                      rd_v_s1;
	logic [IDX_W-1:0]          idx_s1;
	logic [ENTRIES-1:0]        valid_q;
	logic [CNT_W-1:0]          occ_q;
	logic [lruc_pkg::CAP_W-1:0] cap_q;

	logic                      op_q;
	logic [KEY_BITS-1:0]       key_q;
	logic [VALUE_BITS-1:0]     val_q;

	logic                      hit_q, free_q, any_q;
	logic [IDX_W-1:0]          found_q, free_idx_q, best_q, target_q;
	logic [IDX_W-1:0]          hit_rank_q, ref_rank_q;
	logic                      age_all_q;

	logic                      accept;
	logic                      last;
	logic                      vld_s1;
	logic                      age;

	lruc_pkg::lruc_wr_t        wr;
	lruc_pkg::lruc_cmp_t       cmp;
	logic [KEY_BITS-1:0]       key_rdata;
	logic [IDX_W-1:0]          rank_rdata;
	logic [VALUE_BITS-1:0]     val_rdata;
	logic [IDX_W-1:0]          rank_wdata;

	logic [CMP_W-1:0]          cap_ext, eff_cap;
	logic                      have_free;
	logic [IDX_W-1:0]          tgt_d, old_d;
	logic                      age_all_d, insert_d;

	assign accept = start && !busy;
	assign last   = (cnt_q == CNT_W'(ENTRIES));
	assign vld_s1 = valid_q[idx_s1];

	lruc_cmp #(
		.KEY_BITS (KEY_BITS),
		.RANK_W   (IDX_W)
	) u_cmp (
		.key_a  (key_rdata),
		.key_b  (key_q),
		.rank_a (rank_rdata),
		.rank_b (ref_rank_q),
		.res    (cmp)
	);

	lruc_store #(
		.ENTRIES    (ENTRIES),
		.KEY_BITS   (KEY_BITS),
		.VALUE_BITS (VALUE_BITS),
		.IDX_W      (IDX_W)
	) u_store (
		.clk        (clk),
		.wr         (wr),
		.rd_addr    (cnt_q[IDX_W-1:0]),
		.val_raddr  (found_q),
		.kv_waddr   (tgt_d),
		.key_wdata  (key_q),
		.val_wdata  (val_q),
		.rank_waddr (idx_s1),
		.rank_wdata (rank_wdata),
		.key_rdata  (key_rdata),
		.rank_rdata (rank_rdata),
		.val_rdata  (val_rdata)
	);

	always_comb begin
		cap_ext = CMP_W'(cap_q);
		if (cap_ext == '0) begin
			eff_cap = CMP_W'(1);
		end else if (cap_ext > CMP_W'(ENTRIES)) begin
			eff_cap = CMP_W'(ENTRIES);
		end else begin
			eff_cap = cap_ext;
		end
		have_free = (CMP_W'(occ_q) < eff_cap) && free_q;
	end

	always_comb begin
		tgt_d     = best_q;
		old_d     = ref_rank_q;
		age_all_d = 1'b0;
		insert_d  = 1'b0;
		priority if (hit_q) begin
			tgt_d = found_q;
			old_d = hit_rank_q;
		end else if (have_free) begin
			tgt_d     = free_idx_q;
			age_all_d = 1'b1;
			insert_d  = 1'b1;
		end else if (!any_q) begin
			tgt_d     = '0;
			age_all_d = 1'b1;
			insert_d  = 1'b1;
		end
	end

	assign age = vld_s1 && (age_all_q || cmp.lt);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lruc_pkg::ST_IDLE: begin
				if (start) begin
					state_d = lruc_pkg::ST_SCAN;
				end
			end
			lruc_pkg::ST_SCAN: begin
				if (last) begin
					state_d = lruc_pkg::ST_DECIDE;
				end
			end
			lruc_pkg::ST_DECIDE: begin
				if (hit_q || op_q == lruc_pkg::OP_PUT) begin
					state_d = lruc_pkg::ST_TOUCH;
				end else begin
					state_d = lruc_pkg::ST_FINISH;
				end
			end
			lruc_pkg::ST_TOUCH: begin
				if (last) begin
					state_d = lruc_pkg::ST_FINISH;
				end
			end
			lruc_pkg::ST_FINISH: begin
				state_d = start ? lruc_pkg::ST_SCAN : lruc_pkg::ST_IDLE;
			end
			default: state_d = lruc_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		busy       = 1'b1;
		done       = 1'b0;
		wr         = '0;
		rank_wdata = rank_rdata + IDX_W'(1);
		unique case (state_q)
			lruc_pkg::ST_IDLE: begin
				busy = 1'b0;
			end
			lruc_pkg::ST_SCAN: begin
			end
			lruc_pkg::ST_DECIDE: begin
				wr.key_we = (op_q == lruc_pkg::OP_PUT);
				wr.val_we = (op_q == lruc_pkg::OP_PUT);
			end
			lruc_pkg::ST_TOUCH: begin
				if (idx_s1 == target_q) begin
					rank_wdata = '0;
				end
				wr.rank_we = rd_v_s1 && ((idx_s1 == target_q) || age);
			end
			lruc_pkg::ST_FINISH: begin
				busy = 1'b0;
				done = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign hit        = hit_q;
	assign read_value = (hit_q && op_q == lruc_pkg::OP_GET) ?
		lruc_pkg::VALUE_PORT_W'(val_rdata) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lruc_pkg::ST_IDLE;
			cnt_q   <= '0;
			rd_v_s1 <= 1'b0;
			valid_q <= '0;
			occ_q   <= '0;
			cap_q   <= lruc_pkg::CAP_RESET;
			hit_q   <= 1'b0;
			free_q  <= 1'b0;
			any_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			rd_v_s1 <= (state_q == lruc_pkg::ST_SCAN || state_q == lruc_pkg::ST_TOUCH) && !last;
			if (accept) begin
				cnt_q  <= '0;
				hit_q  <= 1'b0;
				free_q <= 1'b0;
				any_q  <= 1'b0;
			end else if (state_q == lruc_pkg::ST_DECIDE) begin
				cnt_q <= '0;
				if (op_q == lruc_pkg::OP_PUT && !hit_q && insert_d) begin
					valid_q[tgt_d] <= 1'b1;
					occ_q          <= occ_q + CNT_W'(1);
				end
			end else if ((state_q == lruc_pkg::ST_SCAN || state_q == lruc_pkg::ST_TOUCH)
				&& !last) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (state_q == lruc_pkg::ST_SCAN && rd_v_s1) begin
				if (vld_s1 && cmp.eq) begin
					hit_q <= 1'b1;
				end
				if (!vld_s1) begin
					free_q <= 1'b1;
				end
				if (vld_s1) begin
					any_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q[IDX_W-1:0];
		if (accept) begin
			op_q  <= operation;
			key_q <= KEY_BITS'(key);
			val_q <= VALUE_BITS'(write_value);
		end
		if (state_q == lruc_pkg::ST_SCAN && rd_v_s1) begin
			if (vld_s1 && cmp.eq && !hit_q) begin
				found_q    <= idx_s1;
				hit_rank_q <= rank_rdata;
			end
			if (!vld_s1 && !free_q) begin
				free_idx_q <= idx_s1;
			end
			if (vld_s1 && (!any_q || cmp.gt)) begin
				best_q     <= idx_s1;
				ref_rank_q <= rank_rdata;
			end
		end
		if (state_q == lruc_pkg::ST_DECIDE) begin
			target_q   <= tgt_d;
			ref_rank_q <= old_d;
			age_all_q  <= age_all_d;
		end
	end

endmodule
